### src/frt_pkg.sv
`timescale 1ns / 1ps
// frt_pkg: shared types and defaults for the fragment reassembly tracker.
// No dependencies.
package frt_pkg;

  // Widths of the header and result fields.
  localparam int IdW     = 48;
  localparam int HdrW    = 16;
  localparam int StatusW = 3;
  localparam int SlotOutW = 3;
  localparam int LenOutW = 32;
  localparam int PendOutW = 4;

  // Default table geometry.
  localparam int DefEntries  = 8;
  localparam int DefMaxFrags = 64;

  typedef enum logic [StatusW-1:0] {
    StStored    = 3'd0,
    StDelivered = 3'd1,
    StOutRange  = 3'd2,
    StMismatch  = 3'd3,
    StDuplicate = 3'd4,
    StFull      = 3'd5,
    StTooMany   = 3'd6
  } status_t;

endpackage

### src/fragment_reassembly_tracker_unit.sv
`timescale 1ns / 1ps
// fragment_reassembly_tracker_unit: associative table of messages under reassembly.
// Depends on frt_pkg.

// One fragment header (msg_id, frag_index, frag_count, payload_len) is taken at each
// clock edge where start is high; busy is always low, so a header may be offered in
// every cycle. Each header produces exactly one result, presented on status, slot,
// msg_length and pending for a single cycle with done high. The receiver cannot
// stall: a result not captured in its done cycle is gone. Throughput is one header
// per cycle; the result passes three register stages: the header register, the
// table lookup/update stage (the id compare against every entry and the write back
// of the chosen entry happen in the same cycle, so a header sees every earlier
// header's effect), and the length multiply stage.
// Status codes: stored, delivered (msg_length valid, entry freed), out of range,
// mismatch, duplicate, table full, too many fragments. slot is meaningful only for
// stored and delivered; pending counts messages still partially received.
module fragment_reassembly_tracker_unit #(
  parameter int ENTRIES   = frt_pkg::DefEntries,
  parameter int MAX_FRAGS = frt_pkg::DefMaxFrags
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [frt_pkg::IdW-1:0]           msg_id,
  input  logic [frt_pkg::HdrW-1:0]          frag_index,
  input  logic [frt_pkg::HdrW-1:0]          frag_count,
  input  logic [frt_pkg::HdrW-1:0]          payload_len,
  output logic                              done,
  output frt_pkg::status_t                  status,
  output logic [frt_pkg::SlotOutW-1:0]      slot,
  output logic [frt_pkg::LenOutW-1:0]       msg_length,
  output logic [frt_pkg::PendOutW-1:0]      pending
);
  import frt_pkg::*;

  // Derived widths.
  localparam int SlotW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int PendW = $clog2(ENTRIES + 1);
  localparam int IdxW  = $clog2(MAX_FRAGS);      // bitmap index
  localparam int CntW  = $clog2(MAX_FRAGS + 1);  // fragment count / arrival count
  localparam int ProdW = HdrW + CntW;

  // ---------------------------------------------------------------------------
  // Stage 1: header register
  // ---------------------------------------------------------------------------
  logic            in_valid;
  logic [IdW-1:0]  q_id;
  logic [HdrW-1:0] q_idx;
  logic [HdrW-1:0] q_cnt;
  logic [HdrW-1:0] q_len;

  assign busy = 1'b0;  // table accepts a header every cycle

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start;
    end
    if (start) begin
      q_id  <= msg_id;
      q_idx <= frag_index;
      q_cnt <= frag_count;
      q_len <= payload_len;
    end
  end

  // ---------------------------------------------------------------------------
  // Reassembly table. Only entry_valid is reset; other fields are written when an
  // entry is allocated and never read while the entry is free.
  // ---------------------------------------------------------------------------
  logic [ENTRIES-1:0]   entry_valid;
  logic [IdW-1:0]       entry_id      [ENTRIES];
  logic [CntW-1:0]      entry_count   [ENTRIES];
  logic [MAX_FRAGS-1:0] arrived_map   [ENTRIES];
  logic [CntW-1:0]      arrived_total [ENTRIES];
  logic                 size_known    [ENTRIES];
  logic [HdrW-1:0]      frag_size     [ENTRIES];
  logic [HdrW-1:0]      last_length   [ENTRIES];
  logic [PendW-1:0]     pending_total;

  // ---------------------------------------------------------------------------
  // Stage 2: lookup, checks and absorb
  // ---------------------------------------------------------------------------
  logic [ENTRIES-1:0]   hit_vec;
  logic                 hit;
  logic [SlotW-1:0]     hit_idx;
  logic                 has_free;
  logic [SlotW-1:0]     free_idx;

  // Fields of the entry the header lands in (hit entry, or a fresh one).
  logic [SlotW-1:0]     sel_idx;
  logic [CntW-1:0]      base_total;
  logic [MAX_FRAGS-1:0] base_map;
  logic                 base_known;
  logic [HdrW-1:0]      base_size;
  logic [HdrW-1:0]      base_last;

  logic                 absorb;
  logic                 is_last;
  logic                 complete;
  logic [CntW-1:0]      total_next;
  logic [MAX_FRAGS-1:0] map_next;
  logic                 known_next;
  logic [HdrW-1:0]      size_next;
  logic [HdrW-1:0]      last_next;
  logic [PendW-1:0]     pending_total_next;
  status_t              res_status;

  logic [31:0]          slot_wide;
  logic [31:0]          pend_wide;

  always_comb begin
    hit_vec  = '0;
    hit      = 1'b0;
    hit_idx  = '0;
    has_free = 1'b0;
    free_idx = '0;
    // Scan from the top so the lowest matching entry wins.
    for (int e = ENTRIES - 1; e >= 0; e--) begin
      hit_vec[e] = entry_valid[e] && (entry_id[e] == q_id);
      if (hit_vec[e]) begin
        hit     = 1'b1;
        hit_idx = SlotW'(e);
      end
      if (!entry_valid[e]) begin
        has_free = 1'b1;
        free_idx = SlotW'(e);
      end
    end
  end

  always_comb begin
    if (hit) begin
      sel_idx    = hit_idx;
      base_total = arrived_total[hit_idx];
      base_map   = arrived_map[hit_idx];
      base_known = size_known[hit_idx];
      base_size  = frag_size[hit_idx];
      base_last  = last_length[hit_idx];
    end else begin
      sel_idx    = free_idx;
      base_total = '0;
      base_map   = '0;
      base_known = 1'b0;
      base_size  = '0;
      base_last  = '0;
    end
  end

  // Checks, in order of precedence.
  always_comb begin
    absorb     = 1'b0;
    res_status = StStored;
    if (hit) begin
      priority if (q_cnt != HdrW'(entry_count[hit_idx])) begin
        res_status = StMismatch;
      end else if (q_idx >= q_cnt) begin
        res_status = StOutRange;
      end else if (arrived_map[hit_idx][q_idx[IdxW-1:0]]) begin
        res_status = StDuplicate;
      end else if (size_known[hit_idx] && (q_idx != q_cnt - 1'b1)
                   && (frag_size[hit_idx] != q_len)) begin
        res_status = StMismatch;
      end else begin
        absorb = 1'b1;
      end
    end else begin
      priority if ((q_cnt == '0) || (q_idx >= q_cnt)) begin
        res_status = StOutRange;
      end else if (q_cnt > HdrW'(MAX_FRAGS)) begin
        res_status = StTooMany;
      end else if (!has_free) begin
        res_status = StFull;
      end else begin
        absorb = 1'b1;
      end
    end
  end

  // Absorb the fragment into the selected entry.
  always_comb begin
    is_last    = (q_idx == q_cnt - 1'b1);
    total_next = base_total + 1'b1;
    map_next   = base_map;
    map_next[q_idx[IdxW-1:0]] = 1'b1;
    known_next = base_known;
    size_next  = base_size;
    last_next  = base_last;
    // A last fragment seen before the size is learned only sets the tail length.
    if ((q_cnt > 16'd1) && is_last && !base_known) begin
      last_next = q_len;
    end else begin
      if (!base_known) begin
        known_next = 1'b1;
        size_next  = q_len;
      end
      if (is_last) begin
        last_next = q_len;
      end
    end
    complete = (HdrW'(total_next) == q_cnt);

    pending_total_next = pending_total;
    if (in_valid && absorb) begin
      if (hit && complete && (pending_total != '0)) begin
        pending_total_next = pending_total - 1'b1;
      end else if (!hit && !complete) begin
        pending_total_next = pending_total + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int e = 0; e < ENTRIES; e++) begin
        entry_valid[e] <= 1'b0;
      end
      pending_total <= '0;
    end else begin
      pending_total <= pending_total_next;
      if (in_valid && absorb) begin
        entry_valid[sel_idx] <= !complete;
      end
    end
    if (in_valid && absorb) begin
      entry_id[sel_idx]      <= q_id;
      entry_count[sel_idx]   <= CntW'(q_cnt);
      arrived_map[sel_idx]   <= map_next;
      arrived_total[sel_idx] <= total_next;
      size_known[sel_idx]    <= known_next;
      frag_size[sel_idx]     <= size_next;
      last_length[sel_idx]   <= last_next;
    end
  end

  // Stage 2 result register; length operands go on to the multiply stage.
  logic             mid_valid;
  status_t          mid_status;
  logic [SlotOutW-1:0] mid_slot;
  logic [PendOutW-1:0] mid_pending;
  logic             mid_deliver;
  logic [HdrW-1:0]  mid_size;
  logic [CntW-1:0]  mid_cnt;
  logic [HdrW-1:0]  mid_last;

  assign slot_wide = 32'(sel_idx);
  assign pend_wide = 32'(pending_total_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else begin
      mid_valid <= in_valid;
    end
    mid_status  <= absorb ? (complete ? StDelivered : StStored) : res_status;
    mid_slot    <= absorb ? slot_wide[SlotOutW-1:0] : '0;
    mid_pending <= pend_wide[PendOutW-1:0];
    mid_deliver <= absorb && complete;
    mid_size    <= size_next;
    mid_cnt     <= CntW'(q_cnt);
    mid_last    <= last_next;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: message length = size * (count - 1) + tail, result register
  // ---------------------------------------------------------------------------
  logic [ProdW-1:0] len_prod;

  assign len_prod = ProdW'(mid_size) * ProdW'(mid_cnt - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= mid_valid;
    end
    status     <= mid_status;
    slot       <= mid_slot;
    pending    <= mid_pending;
    msg_length <= mid_deliver ? (LenOutW'(len_prod) + LenOutW'(mid_last)) : '0;
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  // Every live entry is one pending message.
  a_pending_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(entry_valid) == pending_total)
    else $error("pending count differs from live entries");

  // Ids of live entries are unique.
  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    $onehot0(hit_vec))
    else $error("id matches more than one entry");

  // Table full is only reported when every entry is live.
  a_full_means_full: assert property (@(posedge clk) disable iff (rst)
    in_valid && !absorb && (res_status == StFull) |-> !has_free)
    else $error("table full reported with a free entry");

  // Only deliveries carry a length.
  a_len_only_delivered: assert property (@(posedge clk) disable iff (rst)
    done && (status != StDelivered) |-> (msg_length == '0))
    else $error("length on a non-delivered result");

  // One result per accepted header, via the stage 2 and result registers.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> ##1 mid_valid ##1 done)
    else $error("result did not follow header");

endmodule

### verif/fragment_reassembly_tracker_unit_tb.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for fragment_reassembly_tracker_unit.
// Depends on frt_pkg and fragment_reassembly_tracker_unit; reads no files.
module testbench;
  import frt_pkg::*;

  localparam int Entries     = DefEntries;
  localparam int MaxFrags    = DefMaxFrags;
  localparam int RandomItems = 1700;
  localparam int TailCycles  = 8;        // result pipe is three stages deep
  localparam int CycleLimit  = 400000;

  // One fragment header as offered to the block, plus how the sender paces it.
  typedef struct {
    logic [IdW-1:0]  id;
    logic [HdrW-1:0] index;
    logic [HdrW-1:0] count;
    logic [HdrW-1:0] len;
    int              gap;     // idle cycles before the item is offered
    bit              drain;   // hold the item until every owed result is back
  } header_t;

  // One expected result.
  typedef struct {
    status_t              status;
    logic [SlotOutW-1:0]  slot;
    logic [LenOutW-1:0]   msg_len;
    logic [PendOutW-1:0]  open_cnt;
  } verdict_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic [IdW-1:0]       msg_id = '0;
  logic [HdrW-1:0]      frag_index = '0;
  logic [HdrW-1:0]      frag_count = '0;
  logic [HdrW-1:0]      payload_len = '0;
  logic                 busy;
  logic                 done;
  status_t              status;
  logic [SlotOutW-1:0]  slot;
  logic [LenOutW-1:0]   msg_length;
  logic [PendOutW-1:0]  pending;

  fragment_reassembly_tracker_unit #(
    .ENTRIES   (Entries),
    .MAX_FRAGS (MaxFrags)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .msg_id      (msg_id),
    .frag_index  (frag_index),
    .frag_count  (frag_count),
    .payload_len (payload_len),
    .done        (done),
    .status      (status),
    .slot        (slot),
    .msg_length  (msg_length),
    .pending     (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  header_t  header_q[$];      // headers still to be offered
  verdict_t status_due_q[$];  // results owed by the block, oldest first
  int       fault_n = 0;
  int       cycle_n = 0;

  // ---------------------------------------------------------------------------
  // Shadow reassembly table. Updated once per accepted header, in accept order.
  // ---------------------------------------------------------------------------
  bit              tbl_live  [Entries];
  bit [IdW-1:0]    tbl_id    [Entries];
  bit [HdrW-1:0]   tbl_count [Entries];
  bit [63:0]       tbl_map   [Entries];
  bit [6:0]        tbl_got   [Entries];
  bit              tbl_sized [Entries];
  bit [HdrW-1:0]   tbl_size  [Entries];
  bit [HdrW-1:0]   tbl_last  [Entries];
  int              open_msgs = 0;

  // Mark a fragment as arrived; returns 1 once the message is complete.
  // A last fragment seen before any other one only sets the tail length;
  // the fragment size is then learned from the next non-last fragment.
  function automatic bit absorb_fragment(int e, int idx, bit [HdrW-1:0] len);
    int cnt;
    cnt = tbl_count[e];
    tbl_got[e] = tbl_got[e] + 7'd1;
    tbl_map[e][idx & 63] = 1'b1;
    if (cnt > 1 && idx == cnt - 1 && !tbl_sized[e]) begin
      tbl_last[e] = len;
    end else begin
      if (!tbl_sized[e]) begin
        tbl_sized[e] = 1'b1;
        tbl_size[e]  = len;
      end
      if (idx == cnt - 1) tbl_last[e] = len;
    end
    return int'(tbl_got[e]) == cnt;
  endfunction

  function automatic logic [LenOutW-1:0] message_bytes(int e);
    return LenOutW'(tbl_size[e]) * LenOutW'(tbl_count[e] - 16'd1) + LenOutW'(tbl_last[e]);
  endfunction

  function automatic verdict_t track_fragment(header_t h);
    verdict_t v;
    int       hit;
    int       vacant;
    int       idx;
    int       cnt;
    v.status  = StStored;
    v.slot    = '0;
    v.msg_len = '0;
    hit       = -1;
    vacant    = -1;
    idx       = h.index;
    cnt       = h.count;
    for (int e = 0; e < Entries; e++) begin
      if (tbl_live[e] && tbl_id[e] == h.id && hit < 0) hit = e;
      if (!tbl_live[e] && vacant < 0) vacant = e;
    end
    if (hit >= 0) begin
      // Known message: every reject leaves the entry untouched.
      if (cnt != int'(tbl_count[hit])) begin
        v.status = StMismatch;
      end else if (idx >= cnt) begin
        v.status = StOutRange;
      end else if (tbl_map[hit][idx & 63]) begin
        v.status = StDuplicate;
      end else if (tbl_sized[hit] && idx != cnt - 1 && tbl_size[hit] != h.len) begin
        v.status = StMismatch;
      end else begin
        v.slot = SlotOutW'(hit);
        if (absorb_fragment(hit, idx, h.len)) begin
          v.status      = StDelivered;
          v.msg_len     = message_bytes(hit);
          tbl_live[hit] = 1'b0;
          if (open_msgs > 0) open_msgs--;
        end
      end
    end else if (cnt == 0 || idx >= cnt) begin
      v.status = StOutRange;
    end else if (cnt > MaxFrags) begin
      v.status = StTooMany;
    end else if (vacant < 0) begin
      v.status = StFull;
    end else begin
      // New message takes the lowest free entry; a single-fragment message
      // is delivered at once and never holds it.
      tbl_id[vacant]    = h.id;
      tbl_count[vacant] = h.count;
      tbl_map[vacant]   = '0;
      tbl_got[vacant]   = '0;
      tbl_sized[vacant] = 1'b0;
      tbl_size[vacant]  = '0;
      tbl_last[vacant]  = '0;
      v.slot = SlotOutW'(vacant);
      if (absorb_fragment(vacant, idx, h.len)) begin
        v.status  = StDelivered;
        v.msg_len = message_bytes(vacant);
      end else begin
        tbl_live[vacant] = 1'b1;
        open_msgs++;
      end
    end
    v.open_cnt = PendOutW'(open_msgs);
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers the head of header_q after its gap. The expected result
  // is worked out at the edge where the block takes the item.
  // ---------------------------------------------------------------------------
  header_t offered;
  int      idle_run;

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      idle_run = 0;
    end else begin
      if (start && !busy) status_due_q.push_back(track_fragment(offered));
      if (!(start && busy)) begin
        if (header_q.size() == 0) begin
          start <= 1'b0;
        end else if (header_q[0].drain && status_due_q.size() != 0) begin
          start <= 1'b0;   // pressure point: let the pipe run dry first
        end else if (idle_run < header_q[0].gap) begin
          idle_run++;
          start <= 1'b0;
        end else begin
          offered  = header_q.pop_front();
          idle_run = 0;
          msg_id      <= offered.id;
          frag_index  <= offered.index;
          frag_count  <= offered.count;
          payload_len <= offered.len;
          start       <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: results cannot be stalled, so every done cycle is consumed.
  // ---------------------------------------------------------------------------
  verdict_t want;

  always @(posedge clk) begin
    if (!rst && done) begin
      if (status_due_q.size() == 0) begin
        $display("%0t: unexpected result status %0d slot %0d msg_length %0d pending %0d",
                 $time, status, slot, msg_length, pending);
        fault_n++;
      end else begin
        want = status_due_q.pop_front();
        if (status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, status);
          fault_n++;
        end
        if (slot !== want.slot) begin
          $display("%0t: slot expected %0d got %0d", $time, want.slot, slot);
          fault_n++;
        end
        if (msg_length !== want.msg_len) begin
          $display("%0t: msg_length expected %0d got %0d", $time, want.msg_len, msg_length);
          fault_n++;
        end
        if (pending !== want.open_cnt) begin
          $display("%0t: pending expected %0d got %0d", $time, want.open_cnt, pending);
          fault_n++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus planning. Each plan slot mirrors one message the bench intends
  // to reassemble; with at most Entries plans the table never overflows by
  // accident, so table-full only comes from deliberate probes and single-fragment strays.
  // ---------------------------------------------------------------------------
  bit              plan_used  [Entries];
  logic [IdW-1:0]  plan_id    [Entries];
  int              plan_cnt   [Entries];
  int              plan_pos   [Entries];
  logic [HdrW-1:0] plan_size  [Entries];
  logic [HdrW-1:0] plan_last  [Entries];
  bit              plan_sized [Entries];
  int              plan_seq   [Entries][MaxFrags];
  bit              burst_mode = 1'b0;
  bit              drain_next = 1'b0;

  function automatic logic [IdW-1:0] fresh_id();
    return {16'($urandom()), $urandom()};
  endfunction

  // Lengths lean on the corners now and then.
  function automatic logic [HdrW-1:0] pick_len();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return HdrW'($urandom());
  endfunction

  // Mostly short messages, a few up to the bitmap size.
  function automatic int pick_count();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return 1;
    if (r < 7) return $urandom_range(2, 8);
    if (r < 9) return $urandom_range(9, 32);
    return $urandom_range(33, MaxFrags);
  endfunction

  task automatic push_header(logic [IdW-1:0] id, int idx, int cnt, logic [HdrW-1:0] len);
    header_t h;
    h.id    = id;
    h.index = HdrW'(idx);
    h.count = HdrW'(cnt);
    h.len   = len;
    h.gap   = burst_mode ? 0 : $urandom_range(0, 18);
    h.drain = drain_next;
    drain_next = 1'b0;
    header_q.push_back(h);
  endtask

  task automatic shuffle_from(int p, int first);
    int j;
    int t;
    for (int k = plan_cnt[p] - 1; k > first; k--) begin
      j = $urandom_range(first, k);
      t = plan_seq[p][k];
      plan_seq[p][k] = plan_seq[p][j];
      plan_seq[p][j] = t;
    end
  endtask

  // Fragment order starts as 0..cnt-1; callers shuffle or rearrange it.
  task automatic open_plan(int p, logic [IdW-1:0] id, int cnt);
    plan_used[p]  = 1'b1;
    plan_id[p]    = id;
    plan_cnt[p]   = cnt;
    plan_pos[p]   = 0;
    plan_size[p]  = pick_len();
    plan_last[p]  = pick_len();
    plan_sized[p] = 1'b0;
    for (int k = 0; k < cnt; k++) plan_seq[p][k] = k;
  endtask

  function automatic logic [HdrW-1:0] plan_len(int p, int idx);
    return (idx == plan_cnt[p] - 1) ? plan_last[p] : plan_size[p];
  endfunction

  task automatic send_next(int p);
    int idx;
    idx = plan_seq[p][plan_pos[p]];
    push_header(plan_id[p], idx, plan_cnt[p], plan_len(p, idx));
    if (idx != plan_cnt[p] - 1) plan_sized[p] = 1'b1;
    plan_pos[p]++;
    if (plan_pos[p] == plan_cnt[p]) plan_used[p] = 1'b0;
  endtask

  task automatic emit_wellformed();
    int p;
    p = $urandom_range(0, Entries - 1);
    if (!plan_used[p]) begin
      open_plan(p, fresh_id(), pick_count());
      shuffle_from(p, 0);
    end
    send_next(p);
  endtask

  // Rejects and single-fragment messages that never keep an entry, all on ids the table does not hold.
  task automatic emit_stray();
    int cnt;
    case ($urandom_range(0, 3))
      0: push_header(fresh_id(), $urandom_range(0, 65535), 0, pick_len());
      1: begin
        cnt = $urandom_range(1, 65535);
        push_header(fresh_id(), $urandom_range(cnt, 65535), cnt, pick_len());
      end
      2: begin
        cnt = $urandom_range(MaxFrags + 1, 65535);
        push_header(fresh_id(), $urandom_range(0, cnt - 1), cnt, pick_len());
      end
      default: push_header(fresh_id(), 0, 1, pick_len());
    endcase
  endtask

  // Bad fragments aimed at a message already in the table.
  task automatic emit_spoiler();
    int p;
    int idx;
    int cnt;
    p = $urandom_range(0, Entries - 1);
    if (!plan_used[p] || plan_pos[p] == 0) begin
      emit_stray();
    end else begin
      cnt = plan_cnt[p];
      idx = plan_seq[p][plan_pos[p]];
      case ($urandom_range(0, 3))
        1: push_header(plan_id[p], idx, cnt ^ $urandom_range(1, 65535), plan_len(p, idx));
        2: push_header(plan_id[p], $urandom_range(cnt, 65535), cnt, plan_size[p]);
        3: begin
          if (plan_sized[p] && idx != cnt - 1) begin
            push_header(plan_id[p], idx, cnt, plan_size[p] ^ HdrW'($urandom_range(1, 65535)));
          end else begin
            idx = plan_seq[p][$urandom_range(0, plan_pos[p] - 1)];
            push_header(plan_id[p], idx, cnt, plan_len(p, idx));
          end
        end
        default: begin
          idx = plan_seq[p][$urandom_range(0, plan_pos[p] - 1)];
          push_header(plan_id[p], idx, cnt, plan_len(p, idx));
        end
      endcase
    end
  endtask

  // New message while every entry is held: must come back as table full.
  task automatic emit_probe();
    bit all_held;
    int cnt;
    all_held = 1'b1;
    for (int p = 0; p < Entries; p++)
      if (!plan_used[p] || plan_pos[p] == 0) all_held = 1'b0;
    if (all_held) begin
      cnt = $urandom_range(2, MaxFrags);
      push_header(fresh_id(), $urandom_range(0, cnt - 1), cnt, pick_len());
    end else begin
      emit_wellformed();
    end
  endtask

  task automatic build_directed();
    logic [IdW-1:0] id;
    // single-fragment messages at the id and length corners
    push_header('0, 0, 1, '0);
    push_header('1, 0, 1, '1);
    // new id: zero count, index not below count
    push_header(fresh_id(), 0, 0, pick_len());
    push_header(fresh_id(), 5, 5, pick_len());
    // new id: count just above the bitmap, and the top count
    push_header(fresh_id(), 0, MaxFrags + 1, pick_len());
    push_header(fresh_id(), 65534, 65535, pick_len());
    // full-size message: last fragment first, then the size is learned
    open_plan(0, fresh_id(), MaxFrags);
    plan_size[0] = 16'd100;
    plan_last[0] = 16'd7;
    plan_seq[0][0] = MaxFrags - 1;
    for (int k = 1; k < MaxFrags; k++) plan_seq[0][k] = k - 1;
    shuffle_from(0, 2);
    send_next(0);
    send_next(0);
    id = plan_id[0];
    push_header(id, 0, MaxFrags, 16'd100);         // duplicate
    push_header(id, 1, MaxFrags, 16'd99);          // size disagrees
    push_header(id, 2, MaxFrags - 1, 16'd100);     // count disagrees
    push_header(id, MaxFrags, MaxFrags, 16'd100);  // index past count
    push_header(id, 65535, MaxFrags, 16'd100);
    // fill the rest of the table with two-fragment messages
    for (int p = 1; p < Entries; p++) begin
      open_plan(p, fresh_id(), 2);
      if (p % 2 == 1) begin
        plan_seq[p][0] = 1;
        plan_seq[p][1] = 0;
      end
      send_next(p);
    end
    push_header(fresh_id(), 0, 2, pick_len());    // table full
    for (int p = 1; p < Entries; p++) send_next(p);
  endtask

  task automatic build_random();
    int r;
    drain_next = 1'b1;
    for (int n = 0; n < RandomItems; n++) begin
      if (n % 40 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      if (n % 250 == 0) drain_next = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 75) emit_wellformed();
      else if (r < 85) emit_spoiler();
      else if (r < 95) emit_stray();
      else emit_probe();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Run control.
  // ---------------------------------------------------------------------------
  always @(posedge clk) cycle_n <= cycle_n + 1;

  initial begin
    wait (cycle_n >= CycleLimit);
    $display("fragment_reassembly_tracker_unit verification failed");
    $finish;
  end

  initial begin
    build_directed();
    build_random();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk);
    while (header_q.size() != 0 || start || status_due_q.size() != 0);
    repeat (TailCycles) @(posedge clk);   // catch any stray result
    if (fault_n == 0)
      $display("fragment_reassembly_tracker_unit verification clean");
    else
      $display("fragment_reassembly_tracker_unit verification failed");
    $finish;
  end

endmodule
